>>> src/maf_pkg.sv
// shared constants and types for the moving average filter
// no dependencies; imported by every other file of the block
package maf_pkg;

    localparam int WINDOW_DEF      = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SLOT_BITS = 6;
    localparam int SLOT_SPAN = 1 << SLOT_BITS;
    localparam int LEN_BITS  = 7;
    localparam int SUM_BITS  = 23;
    localparam int AVG_BITS  = 16;

    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(64);
    localparam logic [LEN_BITS-1:0] LEN_ONE   = LEN_BITS'(1);

    // saturation limits on the quotient magnitude
    localparam logic [SUM_BITS-1:0] AVG_POS_LIM = SUM_BITS'(32767);
    localparam logic [SUM_BITS-1:0] AVG_NEG_LIM = SUM_BITS'(32768);
    localparam logic [AVG_BITS-1:0] AVG_MAX     = AVG_BITS'(16'h7fff);
    localparam logic [AVG_BITS-1:0] AVG_MIN     = AVG_BITS'(16'h8000);

    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] dividend;
        logic [LEN_BITS-1:0]        divisor;
    } maf_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } maf_div_status_t;

endpackage

>>> src/moving_average_filter.sv
// moving average filter: one request in, one average out, running sum kept in a register
// requests stall until the last average is loaded; with out_stall low, throughput
// is set by the one-bit-per-cycle divider (23 steps) plus store read and update
// reset: async active low; store entries read as zero through per-slot valid bits cleared
// at once, running sum zero, window_length 64; no clearing pass
// depends on maf_pkg, maf_ram and maf_div
module moving_average_filter
    import maf_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [LEN_BITS-1:0]           cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SLOT_BITS-1:0]          slot,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [AVG_BITS-1:0]    average
);

    // slots above the port range can never be addressed
    localparam int STORE_DEPTH = (WINDOW < SLOT_SPAN) ? WINDOW : SLOT_SPAN;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int EXT_W       = (SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [LEN_BITS-1:0]          len_reg;
    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [STORE_DEPTH-1:0]       valid_reg;
    logic                         in_range_reg;
    logic                         old_valid_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                         out_valid_reg;
    logic signed [AVG_BITS-1:0]   average_reg;

    logic                         accept;
    logic                         in_range;
    logic [ADDR_W-1:0]            addr;
    logic [SAMPLE_BITS-1:0]       rd_data;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic signed [EXT_W-1:0]      wide_sum;
    logic                         store_wr;
    logic                         out_take;
    logic                         out_load;
    maf_div_req_t                 div_req;
    maf_div_status_t              div_stat;
    logic [AVG_BITS-1:0]          div_quo;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_range = (32'(slot) < WINDOW);
    assign addr     = slot[ADDR_W-1:0];

    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (addr_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        old_sample = old_valid_reg ? $signed(rd_data) : '0;
        wide_sum   = EXT_W'(sum_reg) - EXT_W'(old_sample) + EXT_W'(sample_reg);
        store_wr   = (state_reg == ST_UPDATE) && in_range_reg;
        sum_next   = store_wr ? wide_sum[SUM_BITS-1:0] : sum_reg;

        div_req.start    = (state_reg == ST_UPDATE);
        div_req.dividend = sum_next;
        div_req.divisor  = (len_reg == '0) ? LEN_ONE : len_reg;
    end

    maf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .status   (div_stat),
        .quotient (div_quo)
    );

    assign out_take = out_valid_reg && !out_stall;
    assign out_load = (state_reg == ST_DIVIDE) && div_stat.done
                      && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_RESET;
            sum_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            if (store_wr)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_range_reg  <= in_range;
            old_valid_reg <= in_range && valid_reg[addr];
            addr_reg      <= addr;
            sample_reg    <= sample;
        end
        if (out_load)
        begin
            average_reg <= $signed(div_quo);
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

`ifndef SYNTHESIS
    a_update_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPDATE))
        else $error("update did not follow request accept");
    a_divide_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("pending average overwritten");
`endif

endmodule

>>> src/maf_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// depends on maf_pkg for its default parameters
module maf_ram
    import maf_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS_DEF,
    parameter int DEPTH = WINDOW_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/maf_div.sv
// iterative signed divider, one quotient bit per cycle, saturating result
// depends on maf_pkg for widths, limits and the request and status structs
module maf_div
    import maf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  maf_div_req_t        req,
    output maf_div_status_t     status,
    output logic [AVG_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_BITS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_BITS-1:0] quo_reg, quo_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic [LEN_BITS-1:0] dvs_reg, dvs_next;

    logic [LEN_BITS:0]   trial;
    logic                fits;
    logic [SUM_BITS-1:0] magnitude;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_BITS-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        magnitude = req.dividend[SUM_BITS-1] ? SUM_BITS'(-req.dividend)
                                             : SUM_BITS'(req.dividend);

        busy_next = busy_reg;
        done_next = done_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            neg_next  = req.dividend[SUM_BITS-1];
            cnt_next  = CNT_W'(SUM_BITS - 1);
            quo_next  = magnitude;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out the top while quotient bits enter below
            rem_next = fits ? LEN_BITS'(trial - {1'b0, dvs_reg}) : trial[LEN_BITS-1:0];
            quo_next = {quo_reg[SUM_BITS-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        if (neg_reg)
        begin
            quotient = (quo_reg > AVG_NEG_LIM) ? AVG_MIN : AVG_BITS'(-quo_reg);
        end
        else
        begin
            quotient = (quo_reg > AVG_POS_LIM) ? AVG_MAX : quo_reg[AVG_BITS-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == '0 && !req.start) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after last step");
`endif

endmodule
